[design/sa7s_pkg.sv]
`default_nettype none

package sa7s_pkg;

   // Number of samples in the moving average.
   localparam int AVERAGE_LENGTH = 9;

   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 16;
   localparam int BCD_W    = 16;
   localparam int WIDX_W   = 4;
   localparam int STEP_W   = 4;
   localparam int RING_AW  = (AVERAGE_LENGTH > 1) ? $clog2(AVERAGE_LENGTH) : 1;

   // Rounded-up reciprocal of the ring length. Its error term times any 16-bit sum stays
   // below 2**RECIP_SHIFT, so the upper product bits are the exact truncated quotient.
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 20;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((1 << RECIP_SHIFT) + AVERAGE_LENGTH - 1) / AVERAGE_LENGTH);

   typedef enum logic [2:0] {
      ALU_HOLD,
      ALU_CLEAR,
      ALU_ADD,
      ALU_DIV,
      ALU_BCD
   } alu_op_type;

   typedef struct packed {
      alu_op_type           op;
      logic [SAMPLE_W-1:0]  operand;
   } alu_ctrl_type;

   // Common-anode segment codes, active low, bit 7 is the decimal point.
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = 8'hFF;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[design/sample_average_to_seven_segment.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata[11:0] sample
// rsp       out        rsp_tvalid/rsp_tready  tdata[13:0] position, segments, select; tlast
//
// One transaction on req takes a clear, the sum, the divide and the BCD conversion
// in the shared add, multiply and BCD-step unit, then four rsp transactions.
// The sum walks the ring one entry a cycle; the divide is a single reciprocal multiply.
// req_tready is high only while no item is in flight; rsp back-pressure holds the words.
// Synchronous reset clears the ring, the write index and the sequencer.

module sample_average_to_seven_segment
   import sa7s_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] sample, [15:12] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [1:0] digit_position, [9:2] segments,
                                         // [13:10] digit_select, [15:14] zero
   output logic             rsp_tlast
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_BCD  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   localparam logic [1:0] POS_UNITS     = 2'd0;
   localparam logic [1:0] POS_TENS      = 2'd1;
   localparam logic [1:0] POS_THOUSANDS = 2'd3;

   state_type           state_ff;
   state_type           state_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [1:0]          pos_ff;
   logic [1:0]          pos_in;
   logic                ring_we;
   logic [SAMPLE_W-1:0] ring_rdata;
   alu_ctrl_type        alu_ctrl;
   logic [BCD_W-1:0]    bcd;
   logic [3:0]          digit;
   logic [7:0]          segments;
   logic [3:0]          digit_select;

   sa7s_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_we),
      .wr_data (req_tdata[SAMPLE_W-1:0]),
      .rd_addr (step_ff[RING_AW-1:0]),
      .rd_data (ring_rdata)
   );

   sa7s_alu u_alu (
      .clock (clock),
      .ctrl  (alu_ctrl),
      .bcd   (bcd)
   );

   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      pos_in           = pos_ff;
      ring_we          = 1'b0;
      alu_ctrl.op      = ALU_HOLD;
      alu_ctrl.operand = ring_rdata;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ring_we     = 1'b1;
               alu_ctrl.op = ALU_CLEAR;
               step_in     = '0;
               state_in    = ST_SUM;
            end
         end
         ST_SUM: begin
            alu_ctrl.op = ALU_ADD;
            if (step_ff == STEP_W'(AVERAGE_LENGTH - 1)) begin
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DIV: begin
            alu_ctrl.op = ALU_DIV;
            step_in     = '0;
            state_in    = ST_BCD;
         end
         ST_BCD: begin
            alu_ctrl.op = ALU_BCD;
            if (step_ff == STEP_W'(SAMPLE_W - 1)) begin
               step_in  = '0;
               pos_in   = POS_UNITS;
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (pos_ff == POS_THOUSANDS) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         pos_ff   <= POS_UNITS;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pos_ff   <= pos_in;
      end
   end

   // The tens digit carries the lit decimal point.
   always_comb begin
      digit        = bcd[{pos_ff, 2'b00} +: 4];
      segments     = seg_code(digit);
      if (pos_ff == POS_TENS) begin
         segments = segments & 8'h7F;
      end
      digit_select = 4'd1 << pos_ff;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {2'b00, digit_select, segments, pos_ff};
   assign rsp_tlast  = (pos_ff == POS_THOUSANDS);

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input accepted while digit words are pending");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("block not ready after the thousands digit");

   a_accept_sums: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_SUM && step_ff == '0)
      else $error("accepted sample did not start the sum");

   a_first_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> rsp_tdata[1:0] == POS_UNITS)
      else $error("digit run did not start with the units digit");

   a_select_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(rsp_tdata[13:10]))
      else $error("digit select is not one-hot");

endmodule

`default_nettype wire

[design/sa7s_ring.sv]
`default_nettype none

module sa7s_ring
   import sa7s_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire logic [SAMPLE_W-1:0] wr_data,
   input  wire logic [RING_AW-1:0]  rd_addr,
   output logic      [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] ring_ff [AVERAGE_LENGTH];
   logic [WIDX_W-1:0]   wr_idx_ff;
   logic [WIDX_W-1:0]   wr_idx_in;
   logic [WIDX_W-1:0]   wr_slot;
   logic [WIDX_W:0]     wr_next;

   // An index at or past the end of the ring is treated as entry zero.
   always_comb begin
      if ({1'b0, wr_idx_ff} >= (WIDX_W+1)'(AVERAGE_LENGTH)) begin
         wr_slot = '0;
      end else begin
         wr_slot = wr_idx_ff;
      end
      wr_next = {1'b0, wr_slot} + (WIDX_W+1)'(1);
      if (wr_next >= (WIDX_W+1)'(AVERAGE_LENGTH)) begin
         wr_idx_in = '0;
      end else begin
         wr_idx_in = wr_next[WIDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         for (int i = 0; i < AVERAGE_LENGTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (wr_en) begin
         wr_idx_ff <= wr_idx_in;
         ring_ff[wr_slot[RING_AW-1:0]] <= wr_data;
      end
   end

   assign rd_data = ring_ff[rd_addr];

endmodule

`default_nettype wire

[design/sa7s_alu.sv]
`default_nettype none

module sa7s_alu
   import sa7s_pkg::*;
(
   input  wire logic         clock,
   input  wire alu_ctrl_type ctrl,
   output logic [BCD_W-1:0]  bcd
);

   logic [SUM_W-1:0]         acc_ff;
   logic [SUM_W-1:0]         acc_in;
   logic [BCD_W-1:0]         bcd_ff;
   logic [BCD_W-1:0]         bcd_in;
   logic [SUM_W+RECIP_W-1:0] product;
   logic [BCD_W-1:0]         bcd_adj;

   always_comb begin
      // The divide by the ring length is one multiply by its reciprocal.
      product = (SUM_W+RECIP_W)'(acc_ff) * (SUM_W+RECIP_W)'(AVG_RECIP);

      // Double-dabble correction: every BCD digit of five or more gets three added.
      for (int d = 0; d < BCD_W/4; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end

      acc_in = acc_ff;
      bcd_in = bcd_ff;
      case (ctrl.op)
         ALU_CLEAR: begin
            acc_in = '0;
            bcd_in = '0;
         end
         ALU_ADD: begin
            acc_in = acc_ff + SUM_W'(ctrl.operand);
         end
         ALU_DIV: begin
            acc_in = product[RECIP_SHIFT +: SUM_W];
         end
         ALU_BCD: begin
            // The quotient never exceeds the largest sample, so its low bits suffice.
            bcd_in = {bcd_adj[BCD_W-2:0], acc_ff[SAMPLE_W-1]};
            acc_in = {acc_ff[SUM_W-2:0], 1'b0};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      bcd_ff <= bcd_in;
   end

   assign bcd = bcd_ff;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import sa7s_pkg::*;

   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_COUNT   = 75;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 60;

   localparam logic [1:0] POS_UNITS     = 2'd0;
   localparam logic [1:0] POS_TENS      = 2'd1;
   localparam logic [1:0] POS_THOUSANDS = 2'd3;

   // Common-anode codes for the digits 0 through 9, active low.
   localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
   };

   typedef struct packed {
      logic [1:0] position;
      logic [7:0] segments;
      logic [3:0] select;
      logic       last;
   } digit_word_type;

   // Segment bytes of a typed row: [7:0] units up to [31:24] thousands.
   typedef struct packed {
      logic [11:0] sample;
      logic        typed;
      logic [31:0] segments;
   } stimulus_row_type;

   stimulus_row_type directed_rows [DIRECTED_COUNT] = '{
      '{12'h000, 1'b1, 32'hC0C040C0},   // empty ring, average zero
      '{12'hFFF, 1'b1, 32'hC0991292},   // one full-scale sample among zeros: 455
      '{12'hFFF, 1'b0, 32'h0},
      '{12'hFFF, 1'b0, 32'h0},
      '{12'hFFF, 1'b0, 32'h0},
      '{12'hFFF, 1'b0, 32'h0},
      '{12'hFFF, 1'b0, 32'h0},
      '{12'hFFF, 1'b0, 32'h0},
      '{12'hFFF, 1'b0, 32'h0},
      '{12'hFFF, 1'b1, 32'h99C01092},   // index wrapped, ring all full scale: 4095
      '{12'h000, 1'b0, 32'h0},
      '{12'h000, 1'b0, 32'h0},
      '{12'h000, 1'b0, 32'h0},
      '{12'h000, 1'b0, 32'h0},
      '{12'h000, 1'b0, 32'h0},
      '{12'h000, 1'b0, 32'h0},
      '{12'h000, 1'b0, 32'h0},
      '{12'h000, 1'b0, 32'h0},
      '{12'h000, 1'b1, 32'hC0C040C0},   // ring flushed back to zero
      '{12'hAAA, 1'b0, 32'h0},
      '{12'h555, 1'b0, 32'h0},
      '{12'h001, 1'b0, 32'h0},
      '{12'h800, 1'b0, 32'h0},
      '{12'h7FF, 1'b0, 32'h0},
      '{12'hFFE, 1'b0, 32'h0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'h0000;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   logic [SAMPLE_W-1:0] sample_ring [AVERAGE_LENGTH];
   logic [WIDX_W-1:0]   ring_index;
   digit_word_type      expected_digit_words [$];

   int burst_left;
   int samples_sent;
   int words_checked;
   int mismatch_count;
   int quiet_cycles;

   sample_average_to_seven_segment DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic digit_word_type make_digit_word(input logic [1:0] position,
                                                      input logic [7:0] segments);
      digit_word_type word;
      word.position = position;
      word.segments = segments;
      word.select   = 4'b0001 << position;
      word.last     = (position == POS_THOUSANDS);
      return word;
   endfunction

   // Writes the sample into the ring and queues the four digit words of the new average.
   task automatic store_and_average(input logic [11:0] value, input logic typed,
                                    input logic [31:0] typed_segments);
      logic [SUM_W-1:0] total;
      int unsigned      mean;
      int unsigned      scale;
      logic [7:0]       segments;
      if (ring_index >= AVERAGE_LENGTH)
         ring_index = '0;
      sample_ring[ring_index] = value;
      ring_index = (ring_index + 1 >= AVERAGE_LENGTH) ? '0 : ring_index + 1'b1;
      total = '0;
      for (int k = 0; k < AVERAGE_LENGTH; k++)
         total += sample_ring[k];
      mean = total / AVERAGE_LENGTH;
      scale = 1;
      for (int p = POS_UNITS; p <= POS_THOUSANDS; p++) begin
         segments = DIGIT_SEGMENTS[(mean / scale) % 10];
         if (p == POS_TENS)
            segments[7] = 1'b0;
         if (typed)
            segments = typed_segments[8*p +: 8];
         expected_digit_words.push_back(make_digit_word(p[1:0], segments));
         scale *= 10;
      end
   endtask

   // The sender runs in bursts; a burst boundary may drop tvalid for a while.
   task automatic send_sample(input logic [11:0] value, input logic typed,
                              input logic [31:0] typed_segments);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      req_tdata  <= {4'h0, value};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      burst_left--;
      samples_sent++;
      store_and_average(value, typed, typed_segments);
   endtask

   initial begin
      logic [11:0] value;
      logic [11:0] previous;
      for (int k = 0; k < AVERAGE_LENGTH; k++)
         sample_ring[k] = '0;
      ring_index = '0;
      burst_left = 0;
      previous = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_COUNT; r++)
         send_sample(directed_rows[r].sample, directed_rows[r].typed,
                     directed_rows[r].segments);

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         case ($urandom_range(0, 7))
            0:       value = 12'h000;
            1:       value = 12'hFFF;
            2, 3:    value = previous + 12'($urandom_range(0, 40)) - 12'd20;
            default: value = 12'($urandom_range(0, 4095));
         endcase
         previous = value;
         send_sample(value, 1'b0, 32'h0);
      end
      req_tvalid <= 1'b0;

      while (expected_digit_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d samples (%0d directed, %0d random) through the %0d-entry average.",
               samples_sent, DIRECTED_COUNT, RANDOM_COUNT, AVERAGE_LENGTH);
      $display("Checked %0d digit words, %0d mismatches.", words_checked, mismatch_count);
      if (mismatch_count == 0 && expected_digit_words.size() == 0) begin
         $display("sample_average_to_seven_segment test passed");
      end else begin
         $display("sample_average_to_seven_segment test failed");
      end
      $finish;
   end

   // The receiver alternates between stretches of full speed, random stalls and long holds.
   initial begin
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(4, 40);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= 1'b0;
            endcase
         end
      end
   end

   always @(posedge clock) begin : digit_word_check
      digit_word_type want;
      digit_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{position: rsp_tdata[1:0], segments: rsp_tdata[9:2],
                 select: rsp_tdata[13:10], last: rsp_tlast};
         words_checked++;
         if (expected_digit_words.size() == 0) begin
            $error("Unexpected digit word transaction: tdata %h, tlast %b",
                   rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_digit_words.pop_front();
            if (got.position != want.position) begin
               $error("digit_position: expected %0d, got %0d", want.position, got.position);
               mismatch_count++;
            end
            if (got.segments != want.segments) begin
               $error("segments: expected %h, got %h", want.segments, got.segments);
               mismatch_count++;
            end
            if (got.select != want.select) begin
               $error("digit_select: expected %b, got %b", want.select, got.select);
               mismatch_count++;
            end
            if (got.last != want.last) begin
               $error("last: expected %b, got %b", want.last, got.last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("No transaction on either channel for %0d cycles", WATCHDOG_LIMIT);
         $display("sample_average_to_seven_segment test failed");
         $finish;
      end
   end

endmodule

[sample_average_to_seven_segment.f]
design/sa7s_pkg.sv
design/sa7s_ring.sv
design/sa7s_alu.sv
design/sample_average_to_seven_segment.sv
tb/testbench.sv
